/* sv/lwu_pkg.sv */
// Shared types and constants for the link weight update engine.
`default_nettype none

package lwu_pkg;

    localparam int LWU_REG_IDX_W = 3;
    localparam int LWU_CFG_DATA_W = 32;
    localparam int LWU_STAGES = 8;

    localparam logic [30:0] LWU_U31_MAX = 31'h7FFF_FFFF;
    localparam logic signed [31:0] LWU_S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LWU_S32_MIN = 32'sh8000_0000;

    localparam logic [1:0]  LWU_RST_MODE = 2'd0;
    localparam logic [30:0] LWU_RST_LEARNING_RATE = 31'd1677722;
    localparam logic [23:0] LWU_RST_MOMENTUM = 24'd15099494;
    localparam logic [24:0] LWU_RST_DECAY = 25'd0;
    localparam logic signed [31:0] LWU_RST_FLOOR = 32'sh8000_0000;
    localparam logic signed [31:0] LWU_RST_CEILING = 32'sh7FFF_FFFF;
    localparam logic [24:0] LWU_RST_RATE_INC = 25'd1677722;
    localparam logic [24:0] LWU_RST_RATE_DEC = 25'd15099494;

    typedef enum logic [1:0] {
        MODE_STEEPEST = 2'd0,
        MODE_MOMENTUM = 2'd1,
        MODE_DBD      = 2'd2
    } lwu_mode_t;

    typedef enum logic [LWU_REG_IDX_W-1:0] {
        REG_UPDATE_MODE     = 3'd0,
        REG_LEARNING_RATE   = 3'd1,
        REG_MOMENTUM_FACTOR = 3'd2,
        REG_WEIGHT_DECAY    = 3'd3,
        REG_WEIGHT_FLOOR    = 3'd4,
        REG_WEIGHT_CEILING  = 3'd5,
        REG_RATE_INCREMENT  = 3'd6,
        REG_RATE_DECREMENT  = 3'd7
    } lwu_reg_t;

    typedef struct packed {
        logic signed [31:0] weight_in;
        logic signed [31:0] gradient;
        logic signed [31:0] prev_change;
        logic [30:0]        link_rate_in;
    } lwu_item_t;

    typedef struct packed {
        logic signed [31:0] weight_out;
        logic signed [31:0] applied_change;
        logic [30:0]        link_rate_out;
        logic               overflow_flag;
    } lwu_result_t;

endpackage

`default_nettype wire

/* sv/lwu_flow.sv */
// Per-stage valid bits and load enables of the update pipeline.
`default_nettype none

module lwu_flow #(
    parameter int STAGES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic [STAGES-1:0]      load,
    output logic [STAGES-1:0]      valid
);

    logic [STAGES:0]   chain;
    logic [STAGES-1:0] upstream;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    always_comb
    begin
        chain[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            chain[k] = !vld_reg[k] || chain[k+1];
        end
    end

    assign upstream = {vld_reg[STAGES-2:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            vld_next[k] = chain[k] ? upstream[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign load     = chain[STAGES-1:0];
    assign valid    = vld_reg;
    assign in_ready = chain[0];

endmodule

`default_nettype wire

/* sv/link_weight_update_engine.sv */
// The pipeline has 8 register stages; the last one is the output register.
// Throughput: one request per cycle; a stalled output backs up stage by stage,
// and an empty stage still takes the next request.
// Stage 1 holds three multiplies and an add; later stages a multiply or saturation.
// Reset clears all stage valid bits and loads the default register values.
`default_nettype none

module link_weight_update_engine #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  wire lwu_pkg::lwu_item_t                   item,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output lwu_pkg::lwu_result_t                      result,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lwu_pkg::LWU_REG_IDX_W-1:0]    cfg_index,
    input  wire logic [lwu_pkg::LWU_CFG_DATA_W-1:0]   cfg_data
);

    import lwu_pkg::*;

    logic [1:0]         update_mode_reg;
    logic [30:0]        learning_rate_reg;
    logic [23:0]        momentum_factor_reg;
    logic [24:0]        weight_decay_reg;
    logic signed [31:0] weight_floor_reg;
    logic signed [31:0] weight_ceiling_reg;
    logic [24:0]        rate_increment_reg;
    logic [24:0]        rate_decrement_reg;

    logic [LWU_STAGES-1:0] load;
    logic [LWU_STAGES-1:0] vld;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_mode_reg     <= LWU_RST_MODE;
            learning_rate_reg   <= LWU_RST_LEARNING_RATE;
            momentum_factor_reg <= LWU_RST_MOMENTUM;
            weight_decay_reg    <= LWU_RST_DECAY;
            weight_floor_reg    <= LWU_RST_FLOOR;
            weight_ceiling_reg  <= LWU_RST_CEILING;
            rate_increment_reg  <= LWU_RST_RATE_INC;
            rate_decrement_reg  <= LWU_RST_RATE_DEC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UPDATE_MODE:     update_mode_reg     <= cfg_data[1:0];
                REG_LEARNING_RATE:   learning_rate_reg   <= cfg_data[30:0];
                REG_MOMENTUM_FACTOR: momentum_factor_reg <= cfg_data[23:0];
                REG_WEIGHT_DECAY:    weight_decay_reg    <= cfg_data[24:0];
                REG_WEIGHT_FLOOR:    weight_floor_reg    <= $signed(cfg_data[31:0]);
                REG_WEIGHT_CEILING:  weight_ceiling_reg  <= $signed(cfg_data[31:0]);
                REG_RATE_INCREMENT:  rate_increment_reg  <= cfg_data[24:0];
                REG_RATE_DECREMENT:  rate_decrement_reg  <= cfg_data[24:0];
                default:
                begin
                end
            endcase
        end
    end

    lwu_flow #(
        .STAGES (LWU_STAGES)
    ) u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_ready  (item_ready),
        .out_ready (result_ready),
        .load      (load),
        .valid     (vld)
    );

    // Stage 1: rate candidates, momentum and decay products
    logic signed [31:0] s1_w_reg, s1_grad_reg;
    logic [30:0]        s1_rate_reg;
    logic               s1_opp_reg;
    logic [31:0]        s1_rsum_reg;
    logic [55:0]        s1_rprod_reg;
    logic signed [56:0] s1_mom_reg;
    logic signed [57:0] s1_dec_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_w_reg     <= item.weight_in;
            s1_grad_reg  <= item.gradient;
            s1_rate_reg  <= item.link_rate_in;
            s1_opp_reg   <= item.gradient[31] ^ item.prev_change[31];
            s1_rsum_reg  <= {1'b0, item.link_rate_in} + {7'b0, rate_increment_reg};
            s1_rprod_reg <= 56'(item.link_rate_in) * 56'(rate_decrement_reg);
            s1_mom_reg   <= 57'($signed({1'b0, momentum_factor_reg})) * 57'(item.prev_change);
            s1_dec_reg   <= 58'($signed({1'b0, weight_decay_reg})) * 58'(item.weight_in);
        end
    end

    // Stage 2: new link rate, scaled momentum and decay terms
    logic [55:0]        s2_rq;
    logic [30:0]        s2_rate_next;
    logic               s2_ovf_next;
    logic signed [56:0] s2_mom_next;
    logic signed [58:0] s2_dec_next;
    logic signed [31:0] s2_w_reg, s2_grad_reg;
    logic [30:0]        s2_rate_reg;
    logic               s2_ovf_reg;
    logic signed [56:0] s2_mom_reg;
    logic signed [58:0] s2_dec_reg;

    always_comb
    begin
        s2_rq        = s1_rprod_reg >> FRAC_BITS;
        s2_rate_next = s1_rate_reg;
        s2_ovf_next  = 1'b0;
        if (update_mode_reg == MODE_DBD)
        begin
            if (s1_opp_reg)
            begin
                if (s1_rsum_reg > 32'(LWU_U31_MAX))
                begin
                    s2_rate_next = LWU_U31_MAX;
                    s2_ovf_next  = 1'b1;
                end
                else
                begin
                    s2_rate_next = s1_rsum_reg[30:0];
                end
            end
            else if (s2_rq > 56'(LWU_U31_MAX))
            begin
                s2_rate_next = LWU_U31_MAX;
                s2_ovf_next  = 1'b1;
            end
            else
            begin
                s2_rate_next = s2_rq[30:0];
            end
        end
        if (update_mode_reg inside {MODE_MOMENTUM, MODE_DBD})
        begin
            s2_mom_next = s1_mom_reg >>> FRAC_BITS;
        end
        else
        begin
            s2_mom_next = '0;
        end
        s2_dec_next = (-(59'(s1_dec_reg))) >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_w_reg    <= s1_w_reg;
            s2_grad_reg <= s1_grad_reg;
            s2_rate_reg <= s2_rate_next;
            s2_ovf_reg  <= s2_ovf_next;
            s2_mom_reg  <= s2_mom_next;
            s2_dec_reg  <= s2_dec_next;
        end
    end

    // Stage 3: link rate times global rate
    logic signed [31:0] s3_w_reg, s3_grad_reg;
    logic [30:0]        s3_rate_reg;
    logic               s3_ovf_reg;
    logic signed [56:0] s3_mom_reg;
    logic signed [58:0] s3_dec_reg;
    logic [61:0]        s3_eprod_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_w_reg     <= s2_w_reg;
            s3_grad_reg  <= s2_grad_reg;
            s3_rate_reg  <= s2_rate_reg;
            s3_ovf_reg   <= s2_ovf_reg;
            s3_mom_reg   <= s2_mom_reg;
            s3_dec_reg   <= s2_dec_reg;
            s3_eprod_reg <= 62'(s2_rate_reg) * 62'(learning_rate_reg);
        end
    end

    // Stage 4: effective rate
    logic [61:0]        s4_eq;
    logic [30:0]        s4_lr_next;
    logic               s4_ovf_next;
    logic signed [31:0] s4_w_reg, s4_grad_reg;
    logic [30:0]        s4_rate_reg;
    logic               s4_ovf_reg;
    logic signed [56:0] s4_mom_reg;
    logic signed [58:0] s4_dec_reg;
    logic [30:0]        s4_lr_reg;

    always_comb
    begin
        s4_eq       = s3_eprod_reg >> FRAC_BITS;
        s4_lr_next  = learning_rate_reg;
        s4_ovf_next = s3_ovf_reg;
        if (update_mode_reg == MODE_DBD)
        begin
            if (s4_eq > 62'(LWU_U31_MAX))
            begin
                s4_lr_next  = LWU_U31_MAX;
                s4_ovf_next = 1'b1;
            end
            else
            begin
                s4_lr_next = s4_eq[30:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_w_reg    <= s3_w_reg;
            s4_grad_reg <= s3_grad_reg;
            s4_rate_reg <= s3_rate_reg;
            s4_ovf_reg  <= s4_ovf_next;
            s4_mom_reg  <= s3_mom_reg;
            s4_dec_reg  <= s3_dec_reg;
            s4_lr_reg   <= s4_lr_next;
        end
    end

    // Stage 5: effective rate times gradient
    logic signed [31:0] s5_w_reg;
    logic [30:0]        s5_rate_reg;
    logic               s5_ovf_reg;
    logic signed [56:0] s5_mom_reg;
    logic signed [58:0] s5_dec_reg;
    logic signed [63:0] s5_gprod_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_w_reg     <= s4_w_reg;
            s5_rate_reg  <= s4_rate_reg;
            s5_ovf_reg   <= s4_ovf_reg;
            s5_mom_reg   <= s4_mom_reg;
            s5_dec_reg   <= s4_dec_reg;
            s5_gprod_reg <= 64'($signed({1'b0, s4_lr_reg})) * 64'(s4_grad_reg);
        end
    end

    // Stage 6: sum and saturate the change
    logic signed [63:0] s6_grad_term;
    logic signed [63:0] s6_sum;
    logic signed [31:0] s6_change_next;
    logic               s6_ovf_next;
    logic signed [31:0] s6_w_reg;
    logic [30:0]        s6_rate_reg;
    logic               s6_ovf_reg;
    logic signed [31:0] s6_change_reg;

    always_comb
    begin
        s6_grad_term   = (-s5_gprod_reg) >>> FRAC_BITS;
        s6_sum         = s6_grad_term + 64'(s5_mom_reg) + 64'(s5_dec_reg);
        s6_change_next = s6_sum[31:0];
        s6_ovf_next    = s5_ovf_reg;
        if (s6_sum > 64'(LWU_S32_MAX))
        begin
            s6_change_next = LWU_S32_MAX;
            s6_ovf_next    = 1'b1;
        end
        else if (s6_sum < 64'(LWU_S32_MIN))
        begin
            s6_change_next = LWU_S32_MIN;
            s6_ovf_next    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_w_reg      <= s5_w_reg;
            s6_rate_reg   <= s5_rate_reg;
            s6_ovf_reg    <= s6_ovf_next;
            s6_change_reg <= s6_change_next;
        end
    end

    // Stage 7: new weight, saturate and clamp
    logic signed [32:0] s7_wsum;
    logic signed [31:0] s7_wsat;
    logic signed [31:0] s7_wnew_next;
    logic               s7_ovf_next;
    logic signed [31:0] s7_w_reg;
    logic [30:0]        s7_rate_reg;
    logic               s7_ovf_reg;
    logic signed [31:0] s7_wnew_reg;

    always_comb
    begin
        s7_wsum     = 33'(s6_w_reg) + 33'(s6_change_reg);
        s7_wsat     = s7_wsum[31:0];
        s7_ovf_next = s6_ovf_reg;
        if (s7_wsum > 33'(LWU_S32_MAX))
        begin
            s7_wsat     = LWU_S32_MAX;
            s7_ovf_next = 1'b1;
        end
        else if (s7_wsum < 33'(LWU_S32_MIN))
        begin
            s7_wsat     = LWU_S32_MIN;
            s7_ovf_next = 1'b1;
        end
        if (s7_wsat < weight_floor_reg)
        begin
            s7_wnew_next = weight_floor_reg;
        end
        else if (s7_wsat > weight_ceiling_reg)
        begin
            s7_wnew_next = weight_ceiling_reg;
        end
        else
        begin
            s7_wnew_next = s7_wsat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s7_w_reg    <= s6_w_reg;
            s7_rate_reg <= s6_rate_reg;
            s7_ovf_reg  <= s7_ovf_next;
            s7_wnew_reg <= s7_wnew_next;
        end
    end

    // Stage 8: applied change and output register
    logic signed [32:0] s8_diff;
    lwu_result_t        result_next;
    lwu_result_t        result_reg;

    always_comb
    begin
        s8_diff                   = 33'(s7_wnew_reg) - 33'(s7_w_reg);
        result_next.weight_out    = s7_wnew_reg;
        result_next.link_rate_out = s7_rate_reg;
        result_next.applied_change = s8_diff[31:0];
        result_next.overflow_flag = s7_ovf_reg;
        if (s8_diff > 33'(LWU_S32_MAX))
        begin
            result_next.applied_change = LWU_S32_MAX;
            result_next.overflow_flag  = 1'b1;
        end
        else if (s8_diff < 33'(LWU_S32_MIN))
        begin
            result_next.applied_change = LWU_S32_MIN;
            result_next.overflow_flag  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = vld[LWU_STAGES-1];

    a_bounded_weight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (weight_floor_reg <= weight_ceiling_reg) |->
        (result.weight_out >= weight_floor_reg) && (result.weight_out <= weight_ceiling_reg))
        else $error("weight_out outside configured bounds");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !vld[0] |-> item_ready)
        else $error("empty first stage refused a request");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> vld[0])
        else $error("accepted request did not enter the first stage");

endmodule

`default_nettype wire

/* test/tb_link_weight_update_engine.sv */
// Self-checking testbench for the link weight update engine, with a fixed-point predictor.
`timescale 1ns / 100ps

module tb_link_weight_update_engine;

    import lwu_pkg::*;

    localparam int FRAC = 24;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint U31_HI = 64'sd2147483647;
    localparam longint ONE = 64'sd16777216;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int LINKS_PER_PHASE = 75;

    logic clk;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    lwu_item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    lwu_result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [LWU_REG_IDX_W-1:0] cfg_index = '0;
    logic [LWU_CFG_DATA_W-1:0] cfg_data = '0;

    logic [1:0] mode_sel;
    longint glob_rate;
    longint momentum;
    longint decay;
    longint floor_w;
    longint ceil_w;
    longint rate_inc;
    longint rate_dec;

    lwu_item_t links_to_send[$];
    lwu_result_t updates_in_flight[$];

    int faults = 0;
    int links_done = 0;
    int updates_checked = 0;
    int reg_writes = 0;
    int idle_cycles = 0;
    int mode_hits[4] = '{default: 0};
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    link_weight_update_engine #(.FRAC_BITS(FRAC)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi, inout bit ovf);
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo;
        end
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi;
        end
        return v;
    endfunction

    function automatic lwu_result_t update_link(lwu_item_t it);
        longint w_in;
        longint grad;
        longint prev;
        longint rate;
        longint lr;
        longint delta;
        longint w;
        bit ovf;
        lwu_result_t r;
        w_in = $signed(it.weight_in);
        grad = $signed(it.gradient);
        prev = $signed(it.prev_change);
        rate = longint'({1'b0, it.link_rate_in});
        lr = glob_rate;
        ovf = 1'b0;
        if (mode_sel == MODE_DBD)
        begin
            if ((grad < 0) != (prev < 0))
                rate = clip(rate + rate_inc, 0, U31_HI, ovf);
            else
                rate = clip((rate * rate_dec) >>> FRAC, 0, U31_HI, ovf);
            lr = clip((rate * glob_rate) >>> FRAC, 0, U31_HI, ovf);
        end
        delta = (-(lr * grad)) >>> FRAC;
        if (mode_sel == MODE_MOMENTUM || mode_sel == MODE_DBD)
            delta += (momentum * prev) >>> FRAC;
        delta += (-(decay * w_in)) >>> FRAC;
        delta = clip(delta, S32_LO, S32_HI, ovf);
        w = clip(w_in + delta, S32_LO, S32_HI, ovf);
        if (w < floor_w)
            w = floor_w;
        else if (w > ceil_w)
            w = ceil_w;
        r.weight_out = 32'(w);
        r.applied_change = 32'(clip(w - w_in, S32_LO, S32_HI, ovf));
        r.link_rate_out = 31'(rate);
        r.overflow_flag = ovf;
        return r;
    endfunction

    function automatic longint span_pick(longint lo, longint hi, longint typ);
        longint a;
        longint b;
        logic [63:0] off;
        a = lo;
        b = hi;
        case ($urandom_range(9))
            0: return lo;
            1: return hi;
            2, 3, 4, 5:
            begin
                if (-typ > lo)
                    a = -typ;
                if (typ < hi)
                    b = typ;
            end
            default: ;
        endcase
        off = {$urandom, $urandom} % 64'(b - a + 1);
        return a + longint'(off);
    endfunction

    function automatic logic [31:0] reg_pick(lwu_reg_t idx);
        case (idx)
            REG_LEARNING_RATE: return 32'(span_pick(0, U31_HI, 2 * ONE));
            REG_MOMENTUM_FACTOR: return 32'(span_pick(0, ONE - 1, ONE));
            REG_WEIGHT_DECAY: return 32'(span_pick(0, ONE, ONE / 64));
            REG_WEIGHT_FLOOR: return 32'(span_pick(S32_LO, 0, 4 * ONE));
            REG_WEIGHT_CEILING: return 32'(span_pick(0, S32_HI, 4 * ONE));
            default: return 32'(span_pick(0, ONE, ONE));
        endcase
    endfunction

    function automatic lwu_item_t link_item(longint w, longint g, longint p, longint r);
        lwu_item_t it;
        it.weight_in = 32'(w);
        it.gradient = 32'(g);
        it.prev_change = 32'(p);
        it.link_rate_in = 31'(r);
        return it;
    endfunction

    function automatic lwu_item_t random_link();
        return link_item(span_pick(S32_LO, S32_HI, 8 * ONE),
                         span_pick(S32_LO, S32_HI, 4 * ONE),
                         span_pick(S32_LO, S32_HI, ONE),
                         span_pick(0, U31_HI, 2 * ONE));
    endfunction

    task automatic write_reg(lwu_reg_t idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_UPDATE_MODE: mode_sel = data[1:0];
            REG_LEARNING_RATE: glob_rate = longint'(data[30:0]);
            REG_MOMENTUM_FACTOR: momentum = longint'(data[23:0]);
            REG_WEIGHT_DECAY: decay = longint'(data[24:0]);
            REG_WEIGHT_FLOOR: floor_w = $signed(data);
            REG_WEIGHT_CEILING: ceil_w = $signed(data);
            REG_RATE_INCREMENT: rate_inc = longint'(data[24:0]);
            REG_RATE_DECREMENT: rate_dec = longint'(data[24:0]);
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic drain();
        do @(negedge clk);
        while (links_to_send.size() != 0 || item_valid || updates_in_flight.size() != 0);
        repeat (LWU_STAGES + 4) @(posedge clk);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            faults++;
            if (faults <= 10)
                $display("mismatch on update %0d: %s expected %0d got %0d",
                         updates_checked, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && item_ready)
            begin
                updates_in_flight.push_back(update_link(item));
                mode_hits[mode_sel]++;
                links_done++;
            end
            if (!item_valid || item_ready)
            begin
                if (links_to_send.size() != 0 && (no_idle || $urandom_range(99) >= 8))
                begin
                    item <= links_to_send.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= STALL_CYCLES;
            result_ready <= 1'b0;
        end
        else
            result_ready <= no_idle || ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin : check_updates
        lwu_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (updates_in_flight.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("update with no request pending: %p", result);
            end
            else
            begin
                want = updates_in_flight.pop_front();
                check_field("weight_out", want.weight_out, result.weight_out);
                check_field("applied_change", want.applied_change, result.applied_change);
                check_field("link_rate_out", want.link_rate_out, result.link_rate_out);
                check_field("overflow_flag", want.overflow_flag, result.overflow_flag);
                updates_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        mode_sel = LWU_RST_MODE;
        glob_rate = longint'(LWU_RST_LEARNING_RATE);
        momentum = longint'(LWU_RST_MOMENTUM);
        decay = longint'(LWU_RST_DECAY);
        floor_w = LWU_RST_FLOOR;
        ceil_w = LWU_RST_CEILING;
        rate_inc = longint'(LWU_RST_RATE_INC);
        rate_dec = longint'(LWU_RST_RATE_DEC);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // steepest descent at reset settings: field extremes, weight overflow both ways
        @(negedge clk);
        links_to_send.push_back(link_item(0, 0, 0, 0));
        links_to_send.push_back(link_item(S32_HI, S32_HI, S32_HI, U31_HI));
        links_to_send.push_back(link_item(S32_LO, S32_LO, S32_LO, 0));
        links_to_send.push_back(link_item(S32_HI, S32_LO, 0, 1));
        links_to_send.push_back(link_item(S32_LO, S32_HI, -1, U31_HI));
        links_to_send.push_back(link_item(ONE, ONE / 2, -ONE, ONE));
        drain();

        // delta-bar-delta at extreme rates, floor above ceiling
        write_reg(REG_UPDATE_MODE, 32'(MODE_DBD));
        write_reg(REG_LEARNING_RATE, 32'(U31_HI));
        write_reg(REG_MOMENTUM_FACTOR, 32'(ONE - 1));
        write_reg(REG_WEIGHT_DECAY, 32'(ONE));
        write_reg(REG_WEIGHT_FLOOR, 32'(S32_HI));
        write_reg(REG_WEIGHT_CEILING, 32'(S32_LO));
        write_reg(REG_RATE_INCREMENT, 32'(ONE));
        write_reg(REG_RATE_DECREMENT, 32'(ONE));
        @(negedge clk);
        links_to_send.push_back(link_item(S32_LO, -1, 5, U31_HI));
        links_to_send.push_back(link_item(0, 0, -1, 100));
        links_to_send.push_back(link_item(0, -1, 0, 100));
        links_to_send.push_back(link_item(0, 0, 0, U31_HI));
        links_to_send.push_back(link_item(S32_HI, S32_HI, S32_HI, ONE));
        links_to_send.push_back(link_item(ONE, ONE / 16, ONE / 16, ONE));
        drain();

        // unused mode code inside tight bounds
        write_reg(REG_UPDATE_MODE, 32'(MODE_UNUSED));
        write_reg(REG_LEARNING_RATE, 32'(ONE));
        write_reg(REG_WEIGHT_DECAY, 32'(0));
        write_reg(REG_WEIGHT_FLOOR, 32'(-ONE));
        write_reg(REG_WEIGHT_CEILING, 32'(ONE));
        @(negedge clk);
        links_to_send.push_back(link_item(0, 4 * ONE, 0, 5));
        links_to_send.push_back(link_item(0, -4 * ONE, 7, 9));
        links_to_send.push_back(link_item(ONE / 2, ONE / 16, 7, 9));
        links_to_send.push_back(link_item(S32_HI, 0, 0, 0));
        drain();

        // momentum with the largest factor
        write_reg(REG_UPDATE_MODE, 32'(MODE_MOMENTUM));
        write_reg(REG_WEIGHT_DECAY, 32'(ONE / 256));
        write_reg(REG_WEIGHT_FLOOR, 32'(S32_LO));
        write_reg(REG_WEIGHT_CEILING, 32'(S32_HI));
        @(negedge clk);
        links_to_send.push_back(link_item(0, 0, S32_HI, 0));
        links_to_send.push_back(link_item(0, 0, S32_LO, 0));
        links_to_send.push_back(link_item(-ONE, ONE, ONE, ONE));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_reg(REG_UPDATE_MODE, 32'(p % 4));
            for (int r = REG_LEARNING_RATE; r <= REG_RATE_DECREMENT; r++)
                if (p == 0 || $urandom_range(1) == 1)
                    write_reg(lwu_reg_t'(r), reg_pick(lwu_reg_t'(r)));
            @(negedge clk);
            no_idle = (p == 2);
            // hold the result side off once so the pipeline fills and backs up
            hold_req = (p == 5);
            repeat (LINKS_PER_PHASE) links_to_send.push_back(random_link());
            drain();
        end

        repeat (2 * LWU_STAGES) @(posedge clk);
        if (updates_in_flight.size() != 0)
        begin
            faults += updates_in_flight.size();
            $display("%0d updates never arrived", updates_in_flight.size());
        end
        $display("%0d link updates checked, %0d register writes across all settings",
                 updates_checked, reg_writes);
        $display("links per mode: steepest %0d, momentum %0d, delta-bar-delta %0d, unused %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
